// ----- rtl/qpyc_pkg.sv -----
package qpyc_pkg;

  localparam int ARG_W        = 42;
  localparam int MAG_W        = 41;
  localparam int CW           = 44;
  localparam int ZW           = 33;
  localparam int ROOT_W       = 31;
  localparam int RAD_W        = 61;
  localparam int SH_W         = 6;
  localparam int NORM_POS     = 39;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 31;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_NORM = 2'd1;
  localparam logic [1:0] ST_TILT     = 2'd2;

  localparam logic signed [ZW-1:0] Q30_PI      = 33'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 33'sd1686629713;

  localparam logic signed [ZW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158, 33'sd67021686,
    33'sd33543515, 33'sd16775850, 33'sd8388437, 33'sd4194282, 33'sd2097149,
    33'sd1048575, 33'sd524287, 33'sd262143, 33'sd131071, 33'sd65535,
    33'sd32767, 33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
    33'sd1023, 33'sd511, 33'sd255, 33'sd127, 33'sd63,
    33'sd31, 33'sd15, 33'sd8, 33'sd4, 33'sd2};

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] yaw_angle;
  } out_item_t;

  typedef struct packed {
    logic signed [ARG_W-1:0] roll_y;
    logic signed [ARG_W-1:0] roll_x;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic [ROOT_W-1:0]       u;
    logic                    tneg;
    logic                    bad;
  } fr_t;

  typedef struct packed {
    logic tneg;
    logic bad;
  } side_t;

  typedef struct packed {
    logic zero;
    logic xneg;
    logic yneg;
  } qflag_t;

endpackage

// ----- rtl/qpyc_front.sv -----
module qpyc_front import qpyc_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  in_item_t         in_data,
  output logic             out_valid,
  output logic [RAD_W-1:0] out_rad,
  output fr_t              out_side
);

  localparam int FB2    = 2 * QUAT_FRAC_BITS;
  localparam int ONE_SH = (FB2 >= 40) ? 39 : FB2;
  localparam int U_RSH  = (FB2 >= 30) ? FB2 - 30 : 0;
  localparam int U_LSH  = (FB2 < 30) ? 30 - FB2 : 0;
  localparam int N_SH   = (FB2 >= 40) ? 0 : FB2;
  localparam bit ALWAYS_BAD = (FB2 >= 40);
  localparam logic signed [ARG_W-1:0] ONE = ARG_W'(64'd1 << ONE_SH);
  localparam logic [63:0] NORM_HI = 64'd1002001 << N_SH;
  localparam logic [63:0] NORM_LO = 64'd998001 << N_SH;
  localparam logic [19:0] NORM_DEN = 20'd1000000;
  localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(64'd1 << 60);

  // stage 1: products
  logic v1_r;
  logic signed [31:0] xx_r, yy_r, zz_r, ww_r, wx_r, yz_r, wy_r, zx_r, wz_r, xy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= 32'(in_data.quat_x * in_data.quat_x);
      yy_r <= 32'(in_data.quat_y * in_data.quat_y);
      zz_r <= 32'(in_data.quat_z * in_data.quat_z);
      ww_r <= 32'(in_data.quat_w * in_data.quat_w);
      wx_r <= 32'(in_data.quat_w * in_data.quat_x);
      yz_r <= 32'(in_data.quat_y * in_data.quat_z);
      wy_r <= 32'(in_data.quat_w * in_data.quat_y);
      zx_r <= 32'(in_data.quat_z * in_data.quat_x);
      wz_r <= 32'(in_data.quat_w * in_data.quat_z);
      xy_r <= 32'(in_data.quat_x * in_data.quat_y);
    end
  end

  // stage 2: sums, clamp of the asin term
  logic v2_r;
  logic [32:0] n2_r, n2_nxt;
  fr_t s2_r, s2_nxt;
  logic signed [ARG_W-1:0] t, tc, umag;

  always_comb begin
    n2_nxt = 33'($unsigned(xx_r)) + 33'($unsigned(yy_r)) + 33'($unsigned(zz_r))
           + 33'($unsigned(ww_r));
    s2_nxt.roll_y = (ARG_W'(wx_r) + ARG_W'(yz_r)) <<< 1;
    s2_nxt.roll_x = ONE - ((ARG_W'(xx_r) + ARG_W'(yy_r)) <<< 1);
    s2_nxt.yaw_y  = (ARG_W'(wz_r) + ARG_W'(xy_r)) <<< 1;
    s2_nxt.yaw_x  = ONE - ((ARG_W'(yy_r) + ARG_W'(zz_r)) <<< 1);
    t = (ARG_W'(wy_r) - ARG_W'(zx_r)) <<< 1;
    if (t > ONE) begin
      tc = ONE;
    end else if (t < -ONE) begin
      tc = -ONE;
    end else begin
      tc = t;
    end
    s2_nxt.tneg = tc[ARG_W-1];
    umag = s2_nxt.tneg ? -tc : tc;
    s2_nxt.u = ROOT_W'(($unsigned(umag) >> U_RSH) << U_LSH);
    s2_nxt.bad = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r <= n2_nxt;
      s2_r <= s2_nxt;
    end
  end

  // stage 3: u squared, scaled norm
  logic v3_r;
  logic [RAD_W-1:0] uu3_r;
  logic [52:0] nd3_r;
  fr_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uu3_r <= RAD_W'(s2_r.u * s2_r.u);
      nd3_r <= 53'(n2_r * NORM_DEN);
      s3_r  <= s2_r;
    end
  end

  // stage 4: norm window, sqrt radicand
  fr_t s4_nxt;

  always_comb begin
    s4_nxt = s3_r;
    s4_nxt.bad = ALWAYS_BAD || (64'(nd3_r) > NORM_HI) || (64'(nd3_r) < NORM_LO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= RAD_ONE - uu3_r;
      out_side <= s4_nxt;
    end
  end

endmodule

// ----- rtl/qpyc_sqrt.sv -----
module qpyc_sqrt import qpyc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  fr_t               in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output fr_t               out_side
);

  logic [RAD_W-1:0] n_r [0:SQRT_STEPS-1];
  logic [RAD_W-1:0] r_r [0:SQRT_STEPS-1];
  logic             v_r [0:SQRT_STEPS-1];
  fr_t              s_r [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
    localparam logic [RAD_W-1:0] BIT = RAD_W'(64'd1 << (60 - 2 * k));
    logic [RAD_W-1:0] n_in, r_in, trial, n_nxt, r_nxt;
    logic             v_in;
    fr_t              s_in;

    if (k == 0) begin : g_first
      assign n_in = in_rad;
      assign r_in = '0;
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
      assign v_in = v_r[k-1];
      assign s_in = s_r[k-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (n_in >= trial) begin
        n_nxt = n_in - trial;
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_nxt;
        r_r[k] <= r_nxt;
        s_r[k] <= s_in;
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS-1];
  assign out_root  = r_r[SQRT_STEPS-1][ROOT_W-1:0];
  assign out_side  = s_r[SQRT_STEPS-1];

endmodule

// ----- rtl/qpyc_cordic.sv -----
module qpyc_cordic import qpyc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [ARG_W-1:0] in_y,
  input  logic signed [ARG_W-1:0] in_x,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_angle,
  output side_t                out_side
);

  // stage A: magnitudes and quadrant
  logic             va_r;
  logic [MAG_W-1:0] axa_r, aya_r, ma_r;
  qflag_t           fa_r;
  side_t            sa_r;
  logic [MAG_W-1:0] ax_nxt, ay_nxt;

  always_comb begin
    ax_nxt = MAG_W'(in_x[ARG_W-1] ? -in_x : in_x);
    ay_nxt = MAG_W'(in_y[ARG_W-1] ? -in_y : in_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axa_r   <= ax_nxt;
      aya_r   <= ay_nxt;
      ma_r    <= (ax_nxt > ay_nxt) ? ax_nxt : ay_nxt;
      fa_r.zero <= (in_x == '0) && (in_y == '0);
      fa_r.xneg <= in_x[ARG_W-1];
      fa_r.yneg <= in_y[ARG_W-1];
      sa_r    <= in_side;
    end
  end

  // stage B: leading one of the larger magnitude
  logic             vb_r;
  logic [MAG_W-1:0] axb_r, ayb_r;
  logic [SH_W-1:0]  shb_r, sh_nxt;
  qflag_t           fb_r;
  side_t            sb_r;

  always_comb begin
    sh_nxt = '0;
    for (int b = 0; b <= NORM_POS; b++) begin
      if (ma_r[b]) begin
        sh_nxt = SH_W'(NORM_POS - b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axb_r <= axa_r;
      ayb_r <= aya_r;
      shb_r <= sh_nxt;
      fb_r  <= fa_r;
      sb_r  <= sa_r;
    end
  end

  // stage C: align into [2^39, 2^40)
  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  logic                 v_r [0:CORDIC_STEPS];
  qflag_t               f_r [0:CORDIC_STEPS];
  side_t                s_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= $signed(CW'(axb_r) << shb_r);
      y_r[0] <= $signed(CW'(ayb_r) << shb_r);
      z_r[0] <= '0;
      f_r[0] <= fb_r;
      s_r[0] <= sb_r;
    end
  end

  // rotation stages
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    logic signed [CW-1:0] dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (y_r[i] > 0) begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + ATAN_TAB[i];
      end else begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        f_r[i+1] <= f_r[i];
        s_r[i+1] <= s_r[i];
      end
    end
  end

  // clamp and quadrant restore
  logic signed [ZW-1:0] zc, ang_nxt;
  qflag_t               fl;

  always_comb begin
    fl = f_r[CORDIC_STEPS];
    zc = z_r[CORDIC_STEPS];
    if (zc < 0) begin
      zc = '0;
    end else if (zc > Q30_HALF_PI) begin
      zc = Q30_HALF_PI;
    end
    ang_nxt = fl.xneg ? Q30_PI - zc : zc;
    if (fl.yneg) begin
      ang_nxt = -ang_nxt;
    end
    if (fl.zero) begin
      ang_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle <= ang_nxt;
      out_side  <= s_r[CORDIC_STEPS];
    end
  end

endmodule

// ----- rtl/quaternion_planar_yaw_check_core.sv -----
// Quaternion planar yaw check. Takes one quaternion (signed Q2.14 components) per cycle
// and returns status and yaw (signed Q3.13 radians) after 4 front stages (products,
// sums, norm window), a 31-stage bit-per-stage square root for the pitch term, 34
// stages of 30-step vectoring CORDIC (three lanes side by side for roll, pitch and
// yaw) and one output register. Throughput is one item per cycle; the whole pipeline
// holds while a result waits in the output register under out_stall. tilt_limit resets
// to 82; the user writes it by cfg_wr_en / cfg_wr_data only while idle (not enforced).
module quaternion_planar_yaw_check_core import qpyc_pkg::*; #(
  parameter int QUAT_FRAC_BITS  = 14,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);

  localparam int S = 30 - ANGLE_FRAC_BITS;

  logic en;
  logic [14:0] tilt_limit_r;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_limit_r <= 15'd82;
    end else if (cfg_wr_en) begin
      tilt_limit_r <= cfg_wr_data;
    end
  end

  logic             fr_valid;
  logic [RAD_W-1:0] fr_rad;
  fr_t              fr_side;

  qpyc_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
    .clk, .rst_n, .en,
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_valid(fr_valid),
    .out_rad  (fr_rad),
    .out_side (fr_side)
  );

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  fr_t               sq_side;

  qpyc_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (fr_valid),
    .in_rad   (fr_rad),
    .in_side  (fr_side),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  side_t pside_in, pside;
  logic  cd_valid;
  logic signed [ZW-1:0] roll_a, pitch_a, yaw_a;

  assign pside_in.tneg = sq_side.tneg;
  assign pside_in.bad  = sq_side.bad;

  qpyc_cordic u_roll (
    .clk, .rst_n, .en,
    .in_valid (sq_valid),
    .in_y     (sq_side.roll_y),
    .in_x     (sq_side.roll_x),
    .in_side  ('0),
    .out_valid(),
    .out_angle(roll_a),
    .out_side ()
  );

  qpyc_cordic u_pitch (
    .clk, .rst_n, .en,
    .in_valid (sq_valid),
    .in_y     ($signed(ARG_W'(sq_side.u))),
    .in_x     ($signed(ARG_W'(sq_root))),
    .in_side  (pside_in),
    .out_valid(cd_valid),
    .out_angle(pitch_a),
    .out_side (pside)
  );

  qpyc_cordic u_yaw (
    .clk, .rst_n, .en,
    .in_valid (sq_valid),
    .in_y     (sq_side.yaw_y),
    .in_x     (sq_side.yaw_x),
    .in_side  ('0),
    .out_valid(),
    .out_angle(yaw_a),
    .out_side ()
  );

  // tilt test, yaw rounding and saturation
  logic signed [ZW-1:0] pitch_s;
  logic [ZW-1:0]        roll_abs, pitch_abs, tilt;
  logic [45:0]          lim;
  logic signed [ZW+1:0] yaw_rnd;
  logic signed [15:0]   yaw_sat;
  out_item_t            out_nxt;

  always_comb begin
    pitch_s   = pside.tneg ? -pitch_a : pitch_a;
    roll_abs  = $unsigned(roll_a[ZW-1] ? -roll_a : roll_a);
    pitch_abs = $unsigned(pitch_s[ZW-1] ? -pitch_s : pitch_s);
    tilt      = (pitch_abs > roll_abs) ? pitch_abs : roll_abs;
    lim       = 46'(tilt_limit_r) << S;
    yaw_rnd   = (($signed((ZW+2)'(yaw_a))) + $signed((ZW+2)'(64'd1 << (S - 1)))) >>> S;
    if (yaw_rnd > 35'sd32767) begin
      yaw_sat = 16'sh7fff;
    end else if (yaw_rnd < -35'sd32768) begin
      yaw_sat = -16'sh8000;
    end else begin
      yaw_sat = yaw_rnd[15:0];
    end
    if (pside.bad) begin
      out_nxt.status    = ST_NOT_NORM;
      out_nxt.yaw_angle = '0;
    end else if (46'(tilt) > lim) begin
      out_nxt.status    = ST_TILT;
      out_nxt.yaw_angle = '0;
    end else begin
      out_nxt.status    = ST_OK;
      out_nxt.yaw_angle = yaw_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_nxt;
    end
  end

endmodule

// ----- rtl/qpyc_checker.sv -----
module qpyc_checker import qpyc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // no transfer out of a freshly reset block
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_yaw_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.yaw_angle == 16'sd0)
    else $error("yaw given with a failing status");

  a_input_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

endmodule

bind quaternion_planar_yaw_check_core qpyc_checker u_qpyc_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  import qpyc_pkg::*;

  localparam int LATENCY = 70;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam real QSCALE = 16384.0;
  localparam real PI_R = 3.14159265358979;

  localparam longint Q30PI = 64'sd3373259426;
  localparam longint Q30HPI = 64'sd1686629713;
  localparam longint ANG_TAB [0:29] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  quaternion_planar_yaw_check_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  out_item_t   pending_q[$];
  logic [14:0] tilt_lim = 15'd82;
  int          errors = 0;
  bit          quiet = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  // first-quadrant vectoring angle, Q30
  function automatic longint quad_angle(longint unsigned ax, longint unsigned ay);
    longint unsigned m;
    longint x, y, z, dx, dy;
    m = (ax > ay) ? ax : ay;
    z = 0;
    while (m >= (64'd1 << 40)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 39)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    x = ax;
    y = ay;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ANG_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ANG_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Q30HPI) z = Q30HPI;
    return z;
  endfunction

  function automatic longint angle_q30(longint y, longint x);
    longint r;
    if (x == 0 && y == 0) return 0;
    r = quad_angle((x < 0) ? -x : x, (y < 0) ? -y : y);
    if (x < 0) r = Q30PI - r;
    if (y < 0) r = -r;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_item_t yaw_check(in_item_t q);
    out_item_t res;
    longint x, y, z, w, one, roll, pitch, t, yaw, tilt, ap;
    longint unsigned n, u, c;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    res = '0;
    n = x * x + y * y + z * z + w * w;
    if (n * 1000000 > (64'd1002001 << 28) || n * 1000000 < (64'd998001 << 28)) begin
      res.status = ST_NOT_NORM;
      return res;
    end
    one = 64'sd1 << 28;
    roll = angle_q30(2 * (w * x + y * z), one - 2 * (x * x + y * y));
    t = 2 * (w * y - z * x);
    if (t > one) t = one;
    if (t < -one) t = -one;
    u = ((t < 0) ? -t : t) << 2;
    c = int_sqrt((64'd1 << 60) - u * u);
    pitch = angle_q30(u, c);
    tilt = (roll < 0) ? -roll : roll;
    ap = pitch;
    if (ap > tilt) tilt = ap;
    if (tilt > (longint'(tilt_lim) << 17)) begin
      res.status = ST_TILT;
      return res;
    end
    yaw = angle_q30(2 * (w * z + x * y), one - 2 * (y * y + z * z));
    yaw = (yaw + (64'sd1 << 16)) >>> 17;
    if (yaw > 32767) yaw = 32767;
    if (yaw < -32768) yaw = -32768;
    res.status = ST_OK;
    res.yaw_angle = yaw[15:0];
    return res;
  endfunction

  function automatic logic signed [15:0] to_q14(real v);
    int k;
    k = (v >= 0.0) ? $rtoi(v * QSCALE + 0.5) : -$rtoi(-v * QSCALE + 0.5);
    if (k > 32767) k = 32767;
    if (k < -32768) k = -32768;
    return k[15:0];
  endfunction

  function automatic real rnd_real(real lo, real hi);
    return lo + (hi - lo) * ($urandom_range(0, 1000000) / 1000000.0);
  endfunction

  function automatic in_item_t from_euler(real r, real p, real yw);
    in_item_t q;
    real cr, sr, cp, sp, cy, sy;
    cr = $cos(r / 2); sr = $sin(r / 2);
    cp = $cos(p / 2); sp = $sin(p / 2);
    cy = $cos(yw / 2); sy = $sin(yw / 2);
    q.quat_w = to_q14(cr * cp * cy + sr * sp * sy);
    q.quat_x = to_q14(sr * cp * cy - cr * sp * sy);
    q.quat_y = to_q14(cr * sp * cy + sr * cp * sy);
    q.quat_z = to_q14(cr * cp * sy - sr * sp * cy);
    return q;
  endfunction

  function automatic in_item_t make_q(int x, int y, int z, int w);
    in_item_t q;
    q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0]; q.quat_w = w[15:0];
    return q;
  endfunction

  // leaves in_valid high after the transfer
  task automatic send_quat(in_item_t q);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(yaw_check(q));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tilt(logic [14:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tilt_lim = v;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d yaw=%0d", $time,
                 out_data.status, out_data.yaw_angle);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.yaw_angle !== e.yaw_angle) begin
          $display("%0t: yaw_angle expected %0d actual %0d", $time,
                   e.yaw_angle, out_data.yaw_angle);
          errors++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left > 0) || (stall_left > 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("quaternion_planar_yaw_check_core verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    write_tilt(15'd25736);
    send_quat(make_q(0, 0, 0, 0));
    send_quat(make_q(0, 0, 0, 16384));
    send_quat(make_q(0, 0, 0, -16384));
    send_quat(make_q(32767, 32767, 32767, 32767));
    send_quat(make_q(-32768, -32768, -32768, -32768));
    send_quat(make_q(32767, -32768, 0, 0));
    send_quat(make_q(0, 0, 0, 16400));
    send_quat(make_q(0, 0, 0, 16401));
    send_quat(make_q(0, 0, 0, 16368));
    send_quat(make_q(0, 0, 0, 16367));
    send_quat(make_q(0, 0, 16384, 0));
    send_quat(make_q(0, 0, -16384, 0));
    send_quat(make_q(16384, 0, 0, 0));
    send_quat(make_q(0, 11585, 0, 11585));
    send_quat(make_q(0, -11585, 0, 11585));
    send_quat(make_q(0, 11586, 0, 11586));
    send_quat(make_q(11585, 0, 0, -11585));
    send_quat(make_q(8192, 8192, 8192, 8192));
    write_tilt(15'd0);
    send_quat(make_q(0, 0, 0, 16384));
    send_quat(make_q(0, 0, 11585, 11585));
    send_quat(make_q(1, 0, 0, 16384));
    write_tilt(15'd32767);
    send_quat(make_q(16384, 0, 0, 0));
    send_quat(make_q(0, 0, 16384, 0));
  endtask

  task automatic test_random(int count);
    int sel;
    real lim;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      lim = tilt_lim / 8192.0;
      sel = $urandom_range(0, 99);
      if (sel < 45)
        send_quat(from_euler(rnd_real(-1.3, 1.3) * lim, rnd_real(-1.3, 1.3) * lim,
                             rnd_real(-PI_R, PI_R)));
      else if (sel < 70)
        send_quat(from_euler(rnd_real(-PI_R, PI_R), rnd_real(-1.57, 1.57),
                             rnd_real(-PI_R, PI_R)));
      else if (sel < 85)
        send_quat(from_euler(rnd_real(-PI_R, PI_R), rnd_real(-0.05, 0.05) + PI_R / 2 *
                             (($urandom_range(0, 1) == 1) ? 1.0 : -1.0),
                             rnd_real(-PI_R, PI_R)));
      else
        send_quat(make_q($urandom, $urandom, $urandom, $urandom));
    end
    quiet = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    for (int i = 0; i < 150; i++)
      send_quat(from_euler(rnd_real(-0.01, 0.01), rnd_real(-0.01, 0.01),
                           rnd_real(-PI_R, PI_R)));
  endtask

  task automatic test_pause();
    drain_results();
    test_random(50);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_random(100);
    test_directed();
    write_tilt(15'd82);
    test_random(300);
    write_tilt(15'd400);
    test_backpressure();
    test_pause();
    write_tilt(15'd25736);
    test_random(250);
    write_tilt(15'd0);
    test_random(100);
    write_tilt(15'($urandom_range(0, 25736)));
    test_random(200);
    write_tilt(15'($urandom_range(20, 300)));
    test_random(200);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("quaternion_planar_yaw_check_core verification clean");
    end else begin
      $display("quaternion_planar_yaw_check_core verification failed");
    end
    $finish;
  end

endmodule
